### design/dnsqp_pkg.sv
// ----------------------------------------------------------------------------
// dnsqp_pkg
// Shared types and constants for the DNS question name parser.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

    localparam logic [3:0] HEADER_LEN = 4'd12;
    localparam logic [7:0] PTR_MASK   = 8'hC0;
    localparam logic [2:0] TAIL_LEN   = 3'd4;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    // Status codes reported with the final byte of a message
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NOQ      = 3'd2,
        ST_COMPRESS = 3'd3,
        ST_OVERRUN  = 3'd4,
        ST_NOTYPE   = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    // Parse phases, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_LEN    = 5'b00010,
        PH_LABEL  = 5'b00100,
        PH_TAIL   = 5'b01000,
        PH_SKIP   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic        name_valid;
        logic [7:0]  name_byte;
        logic        packet_done;
        logic [2:0]  status;
        logic [15:0] qtype;
    } t_rsp;

    typedef struct packed {
        logic [3:0]  header_count;
        logic        question_present;
        t_phase      phase;
        logic [7:0]  label_remaining;
        logic        name_started;
        logic [2:0]  tail_count;
        logic [15:0] qtype_hold;
        t_status     fail_code;
    } t_state;

    localparam t_state STATE_RESET = '{
        header_count:     4'd0,
        question_present: 1'b0,
        phase:            PH_HEADER,
        label_remaining:  8'd0,
        name_started:     1'b0,
        tail_count:       3'd0,
        qtype_hold:       16'd0,
        fail_code:        ST_OK
    };

endpackage

### design/dns_question_name_parser.sv
// ----------------------------------------------------------------------------
// dns_question_name_parser
// Streams a DNS message byte by byte, emits the first question's dotted name
// and reports a status code and the question type on the final byte.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                    Payload
//  --------  ---  ---------------------------  -------------------------------
//  request   in   i_in_valid / o_in_ready      i_in_data  (data_byte, last_byte)
//  result    out  o_out_valid / i_out_ready    o_out_data (name_valid, name_byte,
//                                              packet_done, status, qtype)
//
//  One request per cycle, sustained while no result stalls in the output
//  register. Each request updates the parser state; a result (name char,
//  dot, or final status) lands in the output register in the cycle after
//  the request is taken. Requests that yield no result (header, length byte
//  of the first label, type/class bytes, skipped bytes) just update state.
//  Reset (synchronous, active low) returns the parser to the header phase
//  and empties the output register.
//  o_in_ready drops only while a result sits unclaimed in the output register.
//
module dns_question_name_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dnsqp_pkg::t_req   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dnsqp_pkg::t_rsp   o_out_data
);

    dnsqp_pkg::t_state r_state, n_state;
    dnsqp_pkg::t_rsp   r_out, n_out;
    logic              r_out_valid, n_out_valid;

    dnsqp_pkg::t_state step_next;
    dnsqp_pkg::t_rsp   step_rsp;
    logic              step_produce;
    logic              in_fire;

    dnsqp_step u_step (
        .i_state   (r_state),
        .i_req     (i_in_data),
        .o_next    (step_next),
        .o_produce (step_produce),
        .o_rsp     (step_rsp)
    );

    // output slot is free when empty or being drained this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (in_fire) begin
            n_state = step_next;
            if (step_produce) begin
                n_out       = step_rsp;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dnsqp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- checks
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output not empty after reset");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result stalled");

    a_mid_result_is_char : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.packet_done) |->
            (o_out_data.name_valid && o_out_data.status == dnsqp_pkg::ST_OK))
        else $error("result without character or status");

    a_qtype_only_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != dnsqp_pkg::ST_OK) |->
            (o_out_data.qtype == 16'd0))
        else $error("qtype reported with failing status");

    a_last_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.last_byte) |=>
            (r_state.phase == dnsqp_pkg::PH_HEADER && r_state.header_count == 4'd0))
        else $error("parser did not restart after final byte");

endmodule

### design/dnsqp_step.sv
// ----------------------------------------------------------------------------
// dnsqp_step
// Per-byte parser update: next state, emitted character and final status.
// ----------------------------------------------------------------------------
module dnsqp_step (
    input  dnsqp_pkg::t_state i_state,
    input  dnsqp_pkg::t_req   i_req,
    output dnsqp_pkg::t_state o_next,
    output logic              o_produce,
    output dnsqp_pkg::t_rsp   o_rsp
);

    dnsqp_pkg::t_state s;
    dnsqp_pkg::t_status st;
    logic       emit;
    logic [7:0] ch;
    logic [7:0] b;

    always_comb begin
        s    = i_state;
        emit = 1'b0;
        ch   = 8'd0;
        b    = i_req.data_byte;
        case (i_state.phase)
            dnsqp_pkg::PH_HEADER: begin
                if ((i_state.header_count == 4'd4 || i_state.header_count == 4'd5)
                        && b != 8'd0) begin
                    s.question_present = 1'b1;
                end
                if (i_state.header_count == dnsqp_pkg::HEADER_LEN - 4'd1) begin
                    s.header_count = dnsqp_pkg::HEADER_LEN;
                    if (s.question_present) begin
                        s.phase = dnsqp_pkg::PH_LEN;
                    end else begin
                        s.fail_code = dnsqp_pkg::ST_NOQ;
                        s.phase     = dnsqp_pkg::PH_SKIP;
                    end
                end else begin
                    s.header_count = i_state.header_count + 4'd1;
                end
            end
            dnsqp_pkg::PH_LEN: begin
                if (b == 8'd0) begin
                    s.phase      = dnsqp_pkg::PH_TAIL;
                    s.tail_count = 3'd0;
                end else if ((b & dnsqp_pkg::PTR_MASK) == dnsqp_pkg::PTR_MASK) begin
                    s.fail_code = dnsqp_pkg::ST_COMPRESS;
                    s.phase     = dnsqp_pkg::PH_SKIP;
                end else begin
                    // dot goes out ahead of every label but the first
                    emit              = i_state.name_started;
                    ch                = i_state.name_started ? dnsqp_pkg::DOT_CHAR : 8'd0;
                    s.name_started    = 1'b1;
                    s.label_remaining = b;
                    s.phase           = dnsqp_pkg::PH_LABEL;
                end
            end
            dnsqp_pkg::PH_LABEL: begin
                emit              = 1'b1;
                ch                = b;
                s.label_remaining = i_state.label_remaining - 8'd1;
                if (i_state.label_remaining == 8'd1) begin
                    s.phase = dnsqp_pkg::PH_LEN;
                end
            end
            dnsqp_pkg::PH_TAIL: begin
                if (i_state.tail_count < 3'd2) begin
                    s.qtype_hold = {i_state.qtype_hold[7:0], b};
                end
                if (i_state.tail_count < dnsqp_pkg::TAIL_LEN) begin
                    s.tail_count = i_state.tail_count + 3'd1;
                end
            end
            default: begin
            end
        endcase

        // status as seen after this byte; first failure wins
        if (s.fail_code != dnsqp_pkg::ST_OK) begin
            st = s.fail_code;
        end else if (s.phase == dnsqp_pkg::PH_HEADER) begin
            st = dnsqp_pkg::ST_SHORT;
        end else if (s.phase == dnsqp_pkg::PH_LABEL) begin
            st = dnsqp_pkg::ST_OVERRUN;
        end else if (s.phase == dnsqp_pkg::PH_LEN) begin
            st = dnsqp_pkg::ST_NOTYPE;
        end else if (s.tail_count < dnsqp_pkg::TAIL_LEN) begin
            st = dnsqp_pkg::ST_NOTYPE;
        end else if (!s.name_started) begin
            st = dnsqp_pkg::ST_EMPTY;
        end else begin
            st = dnsqp_pkg::ST_OK;
        end

        o_rsp.name_valid  = emit;
        o_rsp.name_byte   = ch;
        o_rsp.packet_done = i_req.last_byte;
        o_rsp.status      = i_req.last_byte ? st : dnsqp_pkg::ST_OK;
        o_rsp.qtype       = (i_req.last_byte && st == dnsqp_pkg::ST_OK) ? s.qtype_hold : 16'd0;
        o_produce         = emit | i_req.last_byte;
        o_next            = i_req.last_byte ? dnsqp_pkg::STATE_RESET : s;
    end

endmodule

### tb/dns_question_name_parser_tb.sv
// ----------------------------------------------------------------------------
// dns_question_name_parser_tb
// Feeds DNS messages (directed corner cases, then random well-formed and
// damaged messages) through the parser under random request and result
// stalls, predicts every name character, dot and final status in a
// cycle-free model of the parser, and checks results in order.
// ----------------------------------------------------------------------------
module dns_question_name_parser_tb;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 8;
    localparam int BYTE_TARGET = 1350;
    localparam int CALM_BYTES  = 180;   // no stalls once this few bytes remain
    localparam int HOLD_AFTER  = 400;   // requests taken before the long hold
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 10;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    dnsqp_pkg::t_req   i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    dnsqp_pkg::t_rsp   o_out_data;

    dns_question_name_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stimulus and expectations
    dnsqp_pkg::t_req   msg_bytes_q[$];    // requests not yet offered
    dnsqp_pkg::t_rsp   parsed_q[$];       // results the parser still owes
    logic [7:0]        cur_msg[$];        // message under construction

    int   req_count  = 0;
    int   rsp_count  = 0;
    int   mismatches = 0;
    int   reports    = 0;
    logic req_fire   = 1'b0;        // request taken at the last rising edge
    logic hold_rx    = 1'b0;        // long result hold-off
    int   tx_gap     = 0;
    int   rx_gap     = 0;

    // Parser state mirror
    logic [3:0]         hdr_cnt;
    logic               q_seen;
    dnsqp_pkg::t_phase  ph;
    logic [7:0]         lbl_left;
    logic               name_on;
    logic [2:0]         tail_cnt;
    logic [15:0]        qtype_acc;
    dnsqp_pkg::t_status fail;

    function void clear_parse();
        hdr_cnt   = '0;
        q_seen    = 1'b0;
        ph        = dnsqp_pkg::PH_HEADER;
        lbl_left  = '0;
        name_on   = 1'b0;
        tail_cnt  = '0;
        qtype_acc = '0;
        fail      = dnsqp_pkg::ST_OK;
    endfunction

    // Advance the mirror by one message byte and queue the result it causes
    function void walk_msg_byte(input dnsqp_pkg::t_req r);
        dnsqp_pkg::t_rsp    res;
        dnsqp_pkg::t_status st;
        logic               emit;
        logic [7:0]         ch;
        res  = '0;
        emit = 1'b0;
        ch   = '0;
        case (ph)
            dnsqp_pkg::PH_HEADER: begin
                if ((hdr_cnt == 4'd4 || hdr_cnt == 4'd5) && r.data_byte != 8'd0)
                    q_seen = 1'b1;
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt >= dnsqp_pkg::HEADER_LEN) begin
                    hdr_cnt = dnsqp_pkg::HEADER_LEN;
                    if (q_seen) begin
                        ph = dnsqp_pkg::PH_LEN;
                    end else begin
                        fail = dnsqp_pkg::ST_NOQ;
                        ph   = dnsqp_pkg::PH_SKIP;
                    end
                end
            end
            dnsqp_pkg::PH_LEN: begin
                if (r.data_byte == 8'd0) begin
                    ph       = dnsqp_pkg::PH_TAIL;
                    tail_cnt = '0;
                end else if ((r.data_byte & dnsqp_pkg::PTR_MASK) == dnsqp_pkg::PTR_MASK) begin
                    fail = dnsqp_pkg::ST_COMPRESS;
                    ph   = dnsqp_pkg::PH_SKIP;
                end else begin
                    // dot goes out on the length byte of every later label
                    if (name_on) begin
                        emit = 1'b1;
                        ch   = dnsqp_pkg::DOT_CHAR;
                    end
                    name_on  = 1'b1;
                    lbl_left = r.data_byte;
                    ph       = dnsqp_pkg::PH_LABEL;
                end
            end
            dnsqp_pkg::PH_LABEL: begin
                emit     = 1'b1;
                ch       = r.data_byte;
                lbl_left = lbl_left - 8'd1;
                if (lbl_left == 8'd0)
                    ph = dnsqp_pkg::PH_LEN;
            end
            dnsqp_pkg::PH_TAIL: begin
                if (tail_cnt < 3'd2)
                    qtype_acc = {qtype_acc[7:0], r.data_byte};
                if (tail_cnt < dnsqp_pkg::TAIL_LEN)
                    tail_cnt = tail_cnt + 3'd1;
            end
            default: ;
        endcase

        res.name_valid = emit;
        res.name_byte  = ch;
        if (r.last_byte) begin
            if (fail != dnsqp_pkg::ST_OK)            st = fail;
            else if (ph == dnsqp_pkg::PH_HEADER)     st = dnsqp_pkg::ST_SHORT;
            else if (ph == dnsqp_pkg::PH_LABEL)      st = dnsqp_pkg::ST_OVERRUN;
            else if (ph == dnsqp_pkg::PH_LEN)        st = dnsqp_pkg::ST_NOTYPE;
            else if (tail_cnt < dnsqp_pkg::TAIL_LEN) st = dnsqp_pkg::ST_NOTYPE;
            else if (!name_on)                       st = dnsqp_pkg::ST_EMPTY;
            else                                     st = dnsqp_pkg::ST_OK;
            res.packet_done = 1'b1;
            res.status      = st;
            res.qtype       = (st == dnsqp_pkg::ST_OK) ? qtype_acc : 16'd0;
            clear_parse();
        end
        if (emit || r.last_byte)
            parsed_q.insert(parsed_q.size(), res);
    endfunction

    // ---------------- message construction ----------------

    function void open_msg(input logic [7:0] qd_hi, input logic [7:0] qd_lo);
        cur_msg.delete();
        for (int k = 0; k < 12; k++) begin
            if (k == 4)      cur_msg.insert(cur_msg.size(), qd_hi);
            else if (k == 5) cur_msg.insert(cur_msg.size(), qd_lo);
            else             cur_msg.insert(cur_msg.size(), 8'($urandom));
        end
    endfunction

    function void put_label(input logic [7:0] len);
        cur_msg.insert(cur_msg.size(), len);
        for (int k = 0; k < len; k++)
            cur_msg.insert(cur_msg.size(), 8'($urandom));
    endfunction

    // terminator, type, class
    function void put_tail(input logic [15:0] qt);
        cur_msg.insert(cur_msg.size(), 8'h00);
        cur_msg.insert(cur_msg.size(), qt[15:8]);
        cur_msg.insert(cur_msg.size(), qt[7:0]);
        cur_msg.insert(cur_msg.size(), 8'($urandom));
        cur_msg.insert(cur_msg.size(), 8'($urandom));
    endfunction

    // keep == 0 sends the whole message, else only its first keep bytes
    function void close_msg(input int keep);
        dnsqp_pkg::t_req r;
        while (keep > 0 && cur_msg.size() > keep)
            void'(cur_msg.pop_back());
        foreach (cur_msg[k]) begin
            r.data_byte = cur_msg[k];
            r.last_byte = (k == cur_msg.size() - 1);
            msg_bytes_q.insert(msg_bytes_q.size(), r);
        end
    endfunction

    function logic [7:0] rand_len();
        int pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)     return 8'($urandom_range(8'h40, 8'hBF));
        else if (pick < 4) return 8'($urandom_range(16, 63));
        else               return 8'($urandom_range(1, 15));
    endfunction

    function void random_msg();
        int kind;
        int nlab;
        logic [7:0] hi;
        logic [7:0] lo;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       begin hi = 8'($urandom_range(1, 255)); lo = 8'($urandom); end
            1:       begin hi = 8'h00; lo = 8'($urandom_range(1, 255)); end
            default: begin hi = 8'($urandom); lo = 8'($urandom_range(1, 255)); end
        endcase
        if (kind >= 84 && kind < 89) begin
            hi = 8'h00;
            lo = 8'h00;
        end
        open_msg(hi, lo);
        if (kind >= 94) begin
            // noise, mostly too short for a header
            cur_msg.delete();
            repeat ($urandom_range(1, 20)) cur_msg.insert(cur_msg.size(), 8'($urandom));
            close_msg(0);
            return;
        end
        nlab = (kind >= 89) ? 0 : $urandom_range(1, 4);
        for (int k = 0; k < nlab; k++) begin
            if (kind >= 78 && kind < 84 && k == nlab - 1) begin
                cur_msg.insert(cur_msg.size(), {2'b11, 6'($urandom)});
                cur_msg.insert(cur_msg.size(), 8'($urandom));
            end else begin
                put_label(rand_len());
            end
        end
        put_tail(16'($urandom));
        repeat ($urandom_range(0, 2)) cur_msg.insert(cur_msg.size(), 8'($urandom));
        if (kind >= 70 && kind < 78)
            close_msg($urandom_range(1, cur_msg.size()));
        else
            close_msg(0);
    endfunction

    // ---------------- request driver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !req_fire) begin
            i_in_valid <= 1'b1;         // hold until taken
        end else if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            i_in_valid <= 1'b0;
        end else if (msg_bytes_q.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (msg_bytes_q.size() > CALM_BYTES && (req_count / 128) % 3 != 1
                     && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(1, 12) - 1;
            i_in_valid <= 1'b0;
        end else begin
            i_in_data  <= msg_bytes_q[0];
            msg_bytes_q.delete(0);
            i_in_valid <= 1'b1;
        end
    end

    // ---------------- result ready ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            i_out_ready <= 1'b0;
        end else if (msg_bytes_q.size() > CALM_BYTES && (req_count / 128) % 3 != 2
                     && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Long hold-off so the output register fills and the request side stalls
    initial begin
        wait (req_count >= HOLD_AFTER);
        @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // ---------------- monitor and checker ----------------

    task automatic note_bad(input string what, input dnsqp_pkg::t_rsp want,
                            input dnsqp_pkg::t_rsp got);
        mismatches++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%s at result %0d: expected nv=%0b ch=%02h done=%0b st=%0d qt=%04h",
                     what, rsp_count, want.name_valid, want.name_byte,
                     want.packet_done, want.status, want.qtype);
            $display("    got nv=%0b ch=%02h done=%0b st=%0d qt=%04h",
                     got.name_valid, got.name_byte, got.packet_done,
                     got.status, got.qtype);
        end
    endtask

    always @(posedge i_clk) begin
        dnsqp_pkg::t_rsp want;
        if (!i_rst_n) begin
            clear_parse();
            req_fire = 1'b0;
        end else begin
            req_fire = i_in_valid && o_in_ready;
            if (req_fire) begin
                walk_msg_byte(i_in_data);
                req_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (parsed_q.size() == 0) begin
                    note_bad("unexpected result", '0, o_out_data);
                end else begin
                    want = parsed_q[0];
                    parsed_q.delete(0);
                    if (o_out_data.name_valid  !== want.name_valid  ||
                        o_out_data.name_byte   !== want.name_byte   ||
                        o_out_data.packet_done !== want.packet_done ||
                        o_out_data.status      !== want.status      ||
                        o_out_data.qtype       !== want.qtype)
                        note_bad("mismatch", want, o_out_data);
                end
                rsp_count++;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        clear_parse();

        // header cut short, and a one-byte message
        open_msg(8'h01, 8'h00); close_msg(5);
        open_msg(8'h01, 8'h00); close_msg(1);
        // no question: ends on the twelfth byte, and with a name behind it
        open_msg(8'h00, 8'h00); close_msg(12);
        open_msg(8'h00, 8'h00); put_label(8'd2); put_tail(16'h0001); close_msg(0);
        // header only, question present: type missing
        open_msg(8'h00, 8'h01); close_msg(12);
        // two labels, extreme count and type values, trailing bytes ignored
        open_msg(8'h01, 8'h00); put_label(8'd1); put_label(8'd3);
        put_tail(16'h0001); close_msg(0);
        open_msg(8'hFF, 8'hFF); put_label(8'h3F); put_label(8'h40);
        put_tail(16'hFFFF);
        cur_msg.insert(cur_msg.size(), 8'hA5); cur_msg.insert(cur_msg.size(), 8'h5A);
        close_msg(0);
        // plain lengths with a top bit set, and characters 0x00 and 0xFF
        open_msg(8'h00, 8'h80); put_label(8'h80); put_label(8'hBF);
        cur_msg.insert(cur_msg.size(), 8'd2);
        cur_msg.insert(cur_msg.size(), 8'h00);
        cur_msg.insert(cur_msg.size(), 8'hFF);
        put_tail(16'h0000); close_msg(0);
        // compression pointer after a label and as the first length
        open_msg(8'h00, 8'h02); put_label(8'd2);
        cur_msg.insert(cur_msg.size(), 8'hC0); cur_msg.insert(cur_msg.size(), 8'h0C);
        put_tail(16'h0001); close_msg(0);
        open_msg(8'h01, 8'h01); cur_msg.insert(cur_msg.size(), 8'hFF);
        put_tail(16'h0005);
        close_msg(0);
        // label overrun: final byte inside a label, and on a length byte
        open_msg(8'h01, 8'h00); put_label(8'd3); put_label(8'd4);
        close_msg(cur_msg.size() - 2);
        open_msg(8'h01, 8'h00); put_label(8'd2); cur_msg.insert(cur_msg.size(), 8'd5);
        close_msg(0);
        // type missing: no terminator, and a short tail
        open_msg(8'h01, 8'h00); put_label(8'd2); close_msg(0);
        open_msg(8'h01, 8'h00); put_label(8'd2); put_tail(16'h001C);
        close_msg(cur_msg.size() - 2);
        // empty name
        open_msg(8'h01, 8'h00); put_tail(16'h001C); close_msg(0);

        while (msg_bytes_q.size() < BYTE_TARGET)
            random_msg();

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (msg_bytes_q.size() != 0 || i_in_valid || parsed_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0 && parsed_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * 400000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
design/dnsqp_pkg.sv
design/dnsqp_step.sv
design/dns_question_name_parser.sv
tb/dns_question_name_parser_tb.sv
